// ===== hw/rtl/ffha_pkg.sv =====
package ffha_pkg;

    localparam int ADDR_W = 15;
    localparam int LEN_W  = 16;
    localparam int STAT_W = 3;

    localparam int HEAP_BYTES_DEF   = 32768;
    localparam int ENTRY_COST_DEF   = 16;
    localparam int USED_ENTRIES_DEF = 64;
    localparam int FREE_ENTRIES_DEF = 64;

    // remainder below this takes the whole segment
    localparam int SPLIT_MIN = 16;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_FIT    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic              opcode;
        logic [LEN_W-1:0]  req_bytes;
        logic [ADDR_W-1:0] block_addr;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] grant_addr;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  length;
    } seg_t;

endpackage

// ===== hw/rtl/ffha_seg_ram.sv =====
module ffha_seg_ram #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  ffha_pkg::seg_t           wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output ffha_pkg::seg_t           rdata
);
    import ffha_pkg::*;

    seg_t mem [DEPTH];
    seg_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/first_fit_heap_allocator_unit.sv =====
// Channel   Handshake      Payload  Notes
// request   start / busy   req      taken when start is high and busy is low
// result    done           rsp      valid for the one cycle done is high
//
// Oversize, first-allocate and empty-table requests answer in the cycle after accept.
// Other requests scan a table one entry per cycle through the segment RAM read port;
// a whole-segment take past the first entry or a free then shifts the tail of that
// table down one entry per cycle. Busy stays high through scan and shift, and done
// follows in the next cycle.
// Reset clears counts and sets the top to the heap size; table contents need no clearing.
// Results cannot be held off; busy stays high until done is issued.
module first_fit_heap_allocator_unit #(
    parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
    parameter int ENTRY_COST   = ffha_pkg::ENTRY_COST_DEF,
    parameter int USED_ENTRIES = ffha_pkg::USED_ENTRIES_DEF,
    parameter int FREE_ENTRIES = ffha_pkg::FREE_ENTRIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ffha_pkg::req_t req,
    output logic           done,
    output ffha_pkg::rsp_t rsp
);
    import ffha_pkg::*;

    localparam int UI_W  = $clog2(USED_ENTRIES);
    localparam int FI_W  = $clog2(FREE_ENTRIES);
    localparam int UC_W  = $clog2(USED_ENTRIES + 1);
    localparam int FC_W  = $clog2(FREE_ENTRIES + 1);
    localparam int CNT_W = (UC_W > FC_W) ? UC_W : FC_W;
    localparam int TOP_W = $clog2(HEAP_BYTES + 1);
    localparam int AW    = ((TOP_W > LEN_W) ? TOP_W : LEN_W) + 2;

    localparam logic [AW-1:0] HEAP_A  = AW'(HEAP_BYTES);
    localparam logic [AW-1:0] COST_A  = AW'(ENTRY_COST);
    localparam logic [AW-1:0] COST2_A = AW'(2 * ENTRY_COST);
    localparam logic [AW-1:0] SPLIT_A = AW'(SPLIT_MIN);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FSCAN  = 3'd1;
    localparam logic [2:0] S_USCAN  = 3'd2;
    localparam logic [2:0] S_FSHIFT = 3'd3;
    localparam logic [2:0] S_USHIFT = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [CNT_W-1:0] chk_idx_reg, chk_idx_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] widx_reg, widx_next;
    logic [UC_W-1:0]  used_num_reg, used_num_next;
    logic [FC_W-1:0]  free_cnt_reg, free_cnt_next;
    logic [TOP_W-1:0] top_reg, top_next;
    req_t             req_reg, req_next;
    logic             done_reg, done_next;
    rsp_t             rsp_reg, rsp_next;

    logic            u_we, f_we;
    logic [UI_W-1:0] u_waddr;
    logic [FI_W-1:0] f_waddr;
    seg_t            u_wdata, f_wdata, u_rdata, f_rdata;

    logic [AW-1:0] n_a, top_a, eff_top_a, len_a, s_a, rem_a, ns_a, nt_a;
    logic [FC_W-1:0] eff_fc;

    ffha_seg_ram #(.DEPTH(USED_ENTRIES)) u_used_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .raddr (ptr_reg[UI_W-1:0]),
        .rdata (u_rdata)
    );

    ffha_seg_ram #(.DEPTH(FREE_ENTRIES)) u_free_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (ptr_reg[FI_W-1:0]),
        .rdata (f_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        chk_vld_next  = 1'b0;
        chk_idx_next  = chk_idx_reg;
        pend_next     = 1'b0;
        widx_next     = widx_reg;
        used_num_next = used_num_reg;
        free_cnt_next = free_cnt_reg;
        top_next      = top_reg;
        req_next      = req_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        u_we          = 1'b0;
        u_waddr       = used_num_reg[UI_W-1:0];
        u_wdata       = '0;
        f_we          = 1'b0;
        f_waddr       = '0;
        f_wdata       = '0;

        n_a       = AW'(req_reg.req_bytes);
        top_a     = AW'(top_reg);
        eff_top_a = (used_num_reg == '0) ? HEAP_A : top_a;
        eff_fc    = (used_num_reg == '0) ? '0 : free_cnt_reg;
        len_a     = AW'(f_rdata.length);
        s_a       = AW'(f_rdata.start);
        rem_a     = len_a - n_a;
        ns_a      = s_a + n_a;
        nt_a      = top_a - COST_A;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    rsp_next = '{status: ST_OK, grant_addr: '0};
                    n_a      = AW'(req.req_bytes);
                    if (req.opcode == OP_ALLOC)
                    begin
                        top_next      = eff_top_a[TOP_W-1:0];
                        free_cnt_next = eff_fc;
                        if (n_a > HEAP_A)
                        begin
                            rsp_next.status = ST_TOO_LARGE;
                            done_next       = 1'b1;
                        end
                        else if (eff_fc == '0)
                        begin
                            done_next = 1'b1;
                            if (n_a + COST2_A > eff_top_a)
                            begin
                                rsp_next.status = ST_TOO_LARGE;
                            end
                            else
                            begin
                                u_we          = 1'b1;
                                u_wdata       = '{start: '0, length: req.req_bytes};
                                f_we          = 1'b1;
                                f_wdata.start = req.req_bytes[ADDR_W-1:0];
                                f_wdata.length = LEN_W'(eff_top_a - n_a - COST2_A);
                                used_num_next = used_num_reg + 1'b1;
                                free_cnt_next = FC_W'(1);
                                top_next      = TOP_W'(eff_top_a - COST2_A);
                            end
                        end
                        else
                        begin
                            ptr_next   = '0;
                            state_next = S_FSCAN;
                        end
                    end
                    else if (used_num_reg == '0)
                    begin
                        rsp_next.status = ST_NOT_ALLOC;
                        done_next       = 1'b1;
                    end
                    else
                    begin
                        ptr_next   = '0;
                        state_next = S_USCAN;
                    end
                end
            end

            S_FSCAN:
            begin
                if (chk_vld_reg && (len_a >= n_a))
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if ((used_num_reg >= UC_W'(USED_ENTRIES)) || (top_a < COST_A))
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else if ((chk_idx_reg != '0) || (rem_a < SPLIT_A) || (nt_a >= ns_a))
                    begin
                        rsp_next.grant_addr = f_rdata.start;
                        u_we          = 1'b1;
                        u_wdata       = '{start: f_rdata.start, length: req_reg.req_bytes};
                        used_num_next = used_num_reg + 1'b1;
                        top_next      = TOP_W'(nt_a);
                        f_waddr       = chk_idx_reg[FI_W-1:0];
                        if (rem_a < SPLIT_A)
                        begin
                            if (chk_idx_reg == '0)
                            begin
                                f_we    = 1'b1;
                                f_wdata = '{start: f_rdata.start, length: '0};
                            end
                            else
                            begin
                                // whole segment taken: close the gap
                                done_next  = 1'b0;
                                ptr_next   = chk_idx_reg + 1'b1;
                                state_next = S_FSHIFT;
                            end
                        end
                        else
                        begin
                            f_we          = 1'b1;
                            f_wdata.start = ns_a[ADDR_W-1:0];
                            f_wdata.length = (chk_idx_reg == '0) ? LEN_W'(nt_a - ns_a)
                                                                  : LEN_W'(rem_a);
                        end
                    end
                    else
                    begin
                        rsp_next.status = ST_NO_FIT;
                    end
                end
                else if (chk_vld_reg && (chk_idx_reg + 1'b1 == CNT_W'(free_cnt_reg)))
                begin
                    rsp_next.status = ST_NO_FIT;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (ptr_reg < CNT_W'(free_cnt_reg))
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = ptr_reg;
                    ptr_next     = ptr_reg + 1'b1;
                end
            end

            S_USCAN:
            begin
                if (chk_vld_reg && (u_rdata.start == req_reg.block_addr))
                begin
                    if ((free_cnt_reg >= FC_W'(FREE_ENTRIES)) || (top_a < COST_A))
                    begin
                        rsp_next.status = ST_FULL;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        f_we          = 1'b1;
                        f_waddr       = free_cnt_reg[FI_W-1:0];
                        f_wdata       = u_rdata;
                        free_cnt_next = free_cnt_reg + 1'b1;
                        top_next      = TOP_W'(nt_a);
                        ptr_next      = chk_idx_reg + 1'b1;
                        state_next    = S_USHIFT;
                    end
                end
                else if (chk_vld_reg && (chk_idx_reg + 1'b1 == CNT_W'(used_num_reg)))
                begin
                    rsp_next.status = ST_NOT_ALLOC;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (ptr_reg < CNT_W'(used_num_reg))
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = ptr_reg;
                    ptr_next     = ptr_reg + 1'b1;
                end
            end

            S_FSHIFT:
            begin
                // read entry k+1, write it to k on the next cycle
                f_we    = pend_reg;
                f_waddr = widx_reg[FI_W-1:0];
                f_wdata = f_rdata;
                if (ptr_reg < CNT_W'(free_cnt_reg))
                begin
                    pend_next = 1'b1;
                    widx_next = ptr_reg - 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                end
                else
                begin
                    free_cnt_next = free_cnt_reg - 1'b1;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_USHIFT:
            begin
                u_we    = pend_reg;
                u_waddr = widx_reg[UI_W-1:0];
                u_wdata = u_rdata;
                if (ptr_reg < CNT_W'(used_num_reg))
                begin
                    pend_next = 1'b1;
                    widx_next = ptr_reg - 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                end
                else
                begin
                    used_num_next = used_num_reg - 1'b1;
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            chk_vld_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            used_num_reg <= '0;
            free_cnt_reg <= '0;
            top_reg      <= TOP_W'(HEAP_BYTES);
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            chk_vld_reg  <= chk_vld_next;
            pend_reg     <= pend_next;
            used_num_reg <= used_num_next;
            free_cnt_reg <= free_cnt_next;
            top_reg      <= top_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        chk_idx_reg <= chk_idx_next;
        widx_reg    <= widx_next;
        req_reg     <= req_next;
        rsp_reg     <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_num_reg <= UC_W'(USED_ENTRIES))
        else $error("used count past table depth");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= FC_W'(FREE_ENTRIES))
        else $error("free count past table depth");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("word issued without a request");

    a_fail_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != ST_OK)) |-> (rsp.grant_addr == '0))
        else $error("failed request carries an address");

endmodule
